@@ hw/rtl/rrlp_pkg.sv @@
`default_nettype none

package rrlp_pkg;

    // Widths of the parser's running state.
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PROD_W  = VALUE_W + 4;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [2:0]         t_prefix_pos;
    typedef logic [1:0]         t_field_idx;
    typedef logic [3:0]         t_digit_cnt;

    // Fixed protocol constants.
    localparam t_prefix_pos PREFIX_LEN  = 3'd5;
    localparam t_field_idx  FIELD_COUNT = 2'd3;
    localparam t_digit_cnt  MAX_DIGITS  = 4'd10;

    // Character codes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_QUEST = 8'h3F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Expected prefix character at each matched position.
    function automatic logic [7:0] prefix_char(input t_prefix_pos pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CHAR_R;
            3'd1:    c = CHAR_P;
            3'd2:    c = CHAR_L;
            3'd3:    c = CHAR_QUEST;
            3'd4:    c = CHAR_SPACE;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    // Whitespace that separates fields.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
               (c == CHAR_CR) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/replay_request_line_parser.sv @@
`default_nettype none
// Replay request line parser.
// A terminating zero byte passes through the input register and then loads its verdict
// into the result register, waiting first while a previous verdict is stalled at the output.
// Throughput: one byte per cycle; a terminator waits only while the previous verdict
// is still stalled at the output. Reset clears the parser state and both valid flags;
// data registers are not reset.

module replay_request_line_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_text_byte,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_request_ok,
    output rrlp_pkg::t_value      o_window_start,
    output rrlp_pkg::t_value      o_window_end,
    output rrlp_pkg::t_value      o_max_count
);
    import rrlp_pkg::*;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Parser state.
    t_prefix_pos r_prefix_pos, n_prefix_pos;
    t_field_idx  r_fields_seen, n_fields_seen;
    logic        r_inside, n_inside;
    t_digit_cnt  r_digit_count, n_digit_count;
    logic        r_failed, n_failed;
    t_value      r_field [0:2];

    // Result register.
    logic        r_out_valid;
    logic        r_out_ok;
    t_value      r_out_start;
    t_value      r_out_end;
    t_value      r_out_max;

    logic        w_consume;
    logic        w_is_nul;
    logic        w_load;
    logic        w_is_digit;
    t_field_idx  w_slot;
    t_value      w_base;
    t_digit_cnt  w_count;
    t_value      w_next;
    logic        w_ovf;
    logic        w_field_we;
    logic        w_ok;

    // A terminator needs room in the result register; other bytes always proceed.
    assign w_is_nul  = (r_in_byte == CHAR_NUL);
    assign w_consume = r_in_valid && (!w_is_nul || !r_out_valid || !i_stall);
    assign w_load    = w_consume && w_is_nul;
    assign o_stall   = r_in_valid && !w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_text_byte;
        end
    end

    // Field slot and running value for the current digit.
    assign w_is_digit = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
    assign w_slot     = r_inside ? (r_fields_seen - 2'd1) : r_fields_seen;
    assign w_count    = r_inside ? r_digit_count : '0;

    always_comb begin
        w_base = '0;
        if (r_inside) begin
            case (w_slot)
                2'd0:    w_base = r_field[0];
                2'd1:    w_base = r_field[1];
                2'd2:    w_base = r_field[2];
                default: w_base = '0;
            endcase
        end
    end

    rrlp_digit_acc u_acc (
        .i_value    (w_base),
        .i_digit    (r_in_byte[3:0]),
        .o_value    (w_next),
        .o_overflow (w_ovf)
    );

    // Next parser state for the byte in the input register.
    always_comb begin
        n_prefix_pos  = r_prefix_pos;
        n_fields_seen = r_fields_seen;
        n_inside      = r_inside;
        n_digit_count = r_digit_count;
        n_failed      = r_failed;
        w_field_we    = 1'b0;
        if (w_consume) begin
            if (w_is_nul) begin
                n_prefix_pos  = '0;
                n_fields_seen = '0;
                n_inside      = 1'b0;
                n_digit_count = '0;
                n_failed      = 1'b0;
            end else if (!r_failed) begin
                if (r_prefix_pos != PREFIX_LEN) begin
                    if (r_in_byte == prefix_char(r_prefix_pos)) begin
                        n_prefix_pos = r_prefix_pos + 3'd1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end else if (is_space(r_in_byte)) begin
                    n_inside = 1'b0;
                end else if (!r_inside && (r_fields_seen == FIELD_COUNT)) begin
                    n_failed = 1'b1;
                end else begin
                    if (!r_inside) begin
                        n_fields_seen = r_fields_seen + 2'd1;
                        n_inside      = 1'b1;
                        n_digit_count = '0;
                    end
                    if (!w_is_digit || (w_count >= MAX_DIGITS) || w_ovf) begin
                        n_failed = 1'b1;
                    end else begin
                        w_field_we    = 1'b1;
                        n_digit_count = w_count + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_pos  <= '0;
            r_fields_seen <= '0;
            r_inside      <= 1'b0;
            r_digit_count <= '0;
            r_failed      <= 1'b0;
        end else begin
            r_prefix_pos  <= n_prefix_pos;
            r_fields_seen <= n_fields_seen;
            r_inside      <= n_inside;
            r_digit_count <= n_digit_count;
            r_failed      <= n_failed;
        end
    end

    // Field value storage; only fully opened fields are ever reported.
    always_ff @(posedge i_clk) begin
        if (w_field_we) begin
            r_field[w_slot] <= w_next;
        end
    end

    // Verdict for the line ended by the current terminator.
    assign w_ok = !r_failed && (r_prefix_pos == PREFIX_LEN) &&
                  (r_fields_seen == FIELD_COUNT) &&
                  (r_field[1] >= r_field[0]) && (r_field[2] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ok    <= w_ok;
            r_out_start <= w_ok ? r_field[0] : '0;
            r_out_end   <= w_ok ? r_field[1] : '0;
            r_out_max   <= w_ok ? r_field[2] : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_request_ok   = r_out_ok;
    assign o_window_start = r_out_start;
    assign o_window_end   = r_out_end;
    assign o_max_count    = r_out_max;

`ifndef SYNTH
    // A new result only appears after a terminator was transferred to the parser.
    a_result_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_consume && w_is_nul))
        else $error("result appeared without a terminator");

    // An accepted request has an ordered window and a nonzero maximum.
    a_ok_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok) |->
            ((r_out_max != '0) && (r_out_end >= r_out_start)))
        else $error("accepted request breaks window rules");

    // A rejected request reports all values as zero.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |->
            ((r_out_start == '0) && (r_out_end == '0) && (r_out_max == '0)))
        else $error("rejected request carries nonzero values");

    // Being inside a field implies that field was counted.
    a_inside_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> (r_fields_seen != '0) && (r_prefix_pos == PREFIX_LEN))
        else $error("field open without a counted field");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rrlp_digit_acc.sv @@
`default_nettype none

module rrlp_digit_acc (
    input  wire rrlp_pkg::t_value i_value,
    input  wire logic [3:0]       i_digit,
    output rrlp_pkg::t_value      o_value,
    output logic                  o_overflow
);
    import rrlp_pkg::*;

    logic [PROD_W-1:0] w_wide;
    logic [PROD_W-1:0] w_sum;

    // Multiply by ten as (8x + 2x), then add the new digit.
    assign w_wide = {{(PROD_W-VALUE_W){1'b0}}, i_value};
    assign w_sum  = (w_wide << 3) + (w_wide << 1)
                  + {{(PROD_W-4){1'b0}}, i_digit};

    assign o_value    = w_sum[VALUE_W-1:0];
    assign o_overflow = |w_sum[PROD_W-1:VALUE_W];

endmodule

`default_nettype wire

@@ sim/replay_request_line_parser_checker.sv @@
`default_nettype none

module replay_request_line_parser_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_byte_valid,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_byte_stall,
    input  wire logic             i_verdict_valid,
    input  wire logic             i_verdict_stall,
    input  wire logic             i_request_ok,
    input  wire rrlp_pkg::t_value i_window_start,
    input  wire rrlp_pkg::t_value i_window_end,
    input  wire rrlp_pkg::t_value i_max_count,
    output int                    o_fail_count,
    output int                    o_verdicts_pending
);

    import rrlp_pkg::*;

    typedef struct packed {
        logic   ok;
        t_value start;
        t_value stop;
        t_value count;
    } t_verdict;

    localparam logic [7:0] PREFIX_BYTES [5] = '{CHAR_R, CHAR_P, CHAR_L, CHAR_QUEST, CHAR_SPACE};
    localparam logic [PROD_W-1:0] VALUE_CEILING = PROD_W'(32'hFFFF_FFFF);

    // Running copy of the parser state.
    t_prefix_pos prefix_pos;
    t_field_idx  fields_seen;
    logic        in_field;
    t_digit_cnt  digit_cnt;
    t_value      field_val [3];
    logic        line_bad;

    t_verdict expected_verdicts [$];
    int       mismatch_count;
    int       pending_count;

    assign o_fail_count       = mismatch_count;
    assign o_verdicts_pending = pending_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] verdict check: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
               c == CHAR_CR || c == CHAR_VT || c == CHAR_FF;
    endfunction

    task automatic clear_parser();
        prefix_pos   = '0;
        fields_seen  = '0;
        in_field     = 1'b0;
        digit_cnt    = '0;
        field_val[0] = '0;
        field_val[1] = '0;
        field_val[2] = '0;
        line_bad     = 1'b0;
    endtask

    // Advance the predicted parser by one byte; a terminator queues a verdict.
    task automatic parse_byte(input logic [7:0] c);
        t_verdict          v;
        t_field_idx        idx;
        logic [PROD_W-1:0] acc;
        if (c == CHAR_NUL) begin
            v.ok = !line_bad && prefix_pos == PREFIX_LEN && fields_seen == FIELD_COUNT &&
                   field_val[1] >= field_val[0] && field_val[2] != '0;
            v.start = v.ok ? field_val[0] : '0;
            v.stop  = v.ok ? field_val[1] : '0;
            v.count = v.ok ? field_val[2] : '0;
            expected_verdicts.push_back(v);
            clear_parser();
        end else if (line_bad) begin
            // The rest of a failed line is ignored up to its terminator.
        end else if (prefix_pos < PREFIX_LEN) begin
            if (c == PREFIX_BYTES[prefix_pos]) begin
                prefix_pos = prefix_pos + 1'b1;
            end else begin
                line_bad = 1'b1;
            end
        end else if (is_blank(c)) begin
            in_field = 1'b0;
        end else if (!in_field && fields_seen == FIELD_COUNT) begin
            // A fourth field is never allowed.
            line_bad = 1'b1;
        end else begin
            if (!in_field) begin
                fields_seen = fields_seen + 1'b1;
                in_field    = 1'b1;
                digit_cnt   = '0;
                field_val[fields_seen - 1'b1] = '0;
            end
            idx = fields_seen - 1'b1;
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
                line_bad = 1'b1;
            end else if (digit_cnt >= MAX_DIGITS) begin
                line_bad = 1'b1;
            end else begin
                acc = PROD_W'(field_val[idx]) * PROD_W'(10) + PROD_W'(c - CHAR_ZERO);
                if (acc > VALUE_CEILING) begin
                    line_bad = 1'b1;
                end else begin
                    field_val[idx] = acc[VALUE_W-1:0];
                    digit_cnt      = digit_cnt + 1'b1;
                end
            end
        end
    endtask

    // Compare each verdict transfer with the oldest prediction, then predict.
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            clear_parser();
            expected_verdicts.delete();
        end else begin
            if (i_verdict_valid && !i_verdict_stall) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict with none expected (ok=%0d)",
                                              i_request_ok));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_request_ok !== want.ok)
                        report_mismatch($sformatf("request_ok got %0d want %0d",
                                                  i_request_ok, want.ok));
                    if (i_window_start !== want.start)
                        report_mismatch($sformatf("window_start got %0d want %0d",
                                                  i_window_start, want.start));
                    if (i_window_end !== want.stop)
                        report_mismatch($sformatf("window_end got %0d want %0d",
                                                  i_window_end, want.stop));
                    if (i_max_count !== want.count)
                        report_mismatch($sformatf("max_count got %0d want %0d",
                                                  i_max_count, want.count));
                end
            end
            if (i_byte_valid && !i_byte_stall) begin
                parse_byte(i_byte);
            end
        end
        pending_count = expected_verdicts.size();
    end

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        clear_parser();
    end

endmodule

`default_nettype wire

@@ sim/replay_request_line_parser_tb.sv @@
`default_nettype none

module replay_request_line_parser_tb;

    import rrlp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 1100;

    typedef enum int {
        LINE_GOOD,
        LINE_NOISE,
        LINE_BAD_PREFIX,
        LINE_BAD_CHAR,
        LINE_EXTRA_FIELD,
        LINE_TOO_LONG,
        LINE_OVERFLOW,
        LINE_TRUNCATED
    } t_line_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic [7:0] i_text_byte;
    logic       o_stall;
    logic       o_valid;
    logic       i_stall;
    logic       o_request_ok;
    t_value     o_window_start;
    t_value     o_window_end;
    t_value     o_max_count;

    int         fail_count;
    int         verdicts_pending;
    int         idle_cycles;
    int         random_bytes;
    bit         no_idle;
    logic [7:0] line_bytes [$];

    replay_request_line_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_text_byte    (i_text_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_request_ok   (o_request_ok),
        .o_window_start (o_window_start),
        .o_window_end   (o_window_end),
        .o_max_count    (o_max_count)
    );

    replay_request_line_parser_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_byte_valid       (i_valid),
        .i_byte             (i_text_byte),
        .i_byte_stall       (o_stall),
        .i_verdict_valid    (o_valid),
        .i_verdict_stall    (i_stall),
        .i_request_ok       (o_request_ok),
        .i_window_start     (o_window_start),
        .i_window_end       (o_window_end),
        .i_max_count        (o_max_count),
        .o_fail_count       (fail_count),
        .o_verdicts_pending (verdicts_pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // End the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("replay_request_line_parser: mismatch");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Verdict side: stall for a random number of cycles before each transfer, or not at all while no_idle is set.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 14);
            @(negedge i_clk);
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // One byte transfer, after a random gap with valid low, or with no gap while no_idle is set.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
        send_byte(CHAR_NUL);
        line_bytes.delete();
    endtask

    // Hold the byte side off until every outstanding verdict has arrived.
    task automatic drain_verdicts();
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_pending != 0) @(posedge i_clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    task automatic add_blanks(input int n);
        logic [7:0] blanks [6];
        blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_VT, CHAR_FF};
        repeat (n) line_bytes.push_back(blanks[$urandom_range(0, 5)]);
    endtask

    function automatic int count_digits(input logic [63:0] n);
        int d;
        d = 1;
        while (n >= 64'd10) begin
            n = n / 64'd10;
            d++;
        end
        return d;
    endfunction

    // Decimal text of n after the given number of leading zeros.
    task automatic add_number(input logic [63:0] n, input int zeros);
        logic [7:0] digits [$];
        do begin
            digits.push_front(CHAR_ZERO + 8'(n % 64'd10));
            n = n / 64'd10;
        end while (n != 0);
        repeat (zeros) line_bytes.push_back(CHAR_ZERO);
        foreach (digits[i]) line_bytes.push_back(digits[i]);
    endtask

    // Any byte that is neither a terminator, a digit nor whitespace.
    function automatic logic [7:0] rand_bad_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SPACE ||
                   (b >= CHAR_TAB && b <= CHAR_CR));
        return b;
    endfunction

    // Field values spread over every magnitude, with the extremes favored.
    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 4))
            0:       return 64'($urandom_range(0, 9));
            1:       return 64'($urandom_range(0, 999));
            2:       return 64'($urandom_range(0, 999999));
            3:       return {32'd0, $urandom};
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 64'd0;
                    1:       return 64'd1;
                    2:       return 64'hFFFF_FFFE;
                    default: return 64'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // A request line with random content, spoiled in the way the kind says.
    task automatic build_request(input t_line_kind kind);
        logic [63:0] vals [3];
        logic [63:0] tmp;
        int          flawed;
        int          zeros;
        int          cut;
        flawed = $urandom_range(0, 2);
        vals[0] = rand_value();
        vals[1] = rand_value();
        vals[2] = rand_value();
        if (vals[0] > vals[1] && $urandom_range(0, 4) != 0) begin
            tmp     = vals[0];
            vals[0] = vals[1];
            vals[1] = tmp;
        end
        if (vals[2] == 0 && $urandom_range(0, 3) != 0) vals[2] = 64'd1;
        add_text("RPL? ");
        if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
        for (int k = 0; k < 3; k++) begin
            if (k > 0) add_blanks($urandom_range(1, 3));
            if (kind == LINE_OVERFLOW && k == flawed)
                vals[k] = 64'd4294967296 + ({$urandom, $urandom} % 64'd5705032704);
            zeros = 0;
            if (kind == LINE_TOO_LONG && k == flawed)
                zeros = 11 - count_digits(vals[k]) + $urandom_range(0, 1);
            else if (kind != LINE_OVERFLOW && $urandom_range(0, 7) == 0)
                zeros = $urandom_range(0, 10 - count_digits(vals[k]));
            add_number(vals[k], zeros);
            if (kind == LINE_BAD_CHAR && k == flawed) begin
                line_bytes.push_back(rand_bad_byte());
                if ($urandom_range(0, 1) == 0) add_number(rand_value(), 0);
            end
        end
        if (kind == LINE_EXTRA_FIELD) begin
            add_blanks($urandom_range(1, 2));
            if ($urandom_range(0, 1) == 0) add_number(rand_value(), 0);
            else line_bytes.push_back(rand_bad_byte());
        end
        if ($urandom_range(0, 1) == 0) add_blanks($urandom_range(1, 2));
        if (kind == LINE_TRUNCATED) begin
            cut = $urandom_range(0, line_bytes.size() - 1);
            while (line_bytes.size() > cut) void'(line_bytes.pop_back());
        end
    endtask

    // A prefix that goes wrong at a random position, then random bytes.
    task automatic build_bad_prefix();
        logic [7:0] prefix [5];
        logic [7:0] b;
        int         pos;
        prefix = '{CHAR_R, CHAR_P, CHAR_L, CHAR_QUEST, CHAR_SPACE};
        pos = $urandom_range(0, 4);
        for (int i = 0; i < pos; i++) line_bytes.push_back(prefix[i]);
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == prefix[pos]);
        line_bytes.push_back(b);
        repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(1, 255)));
    endtask

    // Stimulus: reset, directed lines, then random lines.
    initial begin
        int         pick;
        int         lines;
        t_line_kind kind;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_text_byte  = CHAR_NUL;
        no_idle      = 1'b0;
        idle_cycles  = 0;
        random_bytes = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Valid line with every separator other than a plain space, and the field extremes.
        add_text("RPL? 0");
        line_bytes.push_back(CHAR_TAB);
        add_text("4294967295");
        line_bytes.push_back(CHAR_LF);
        line_bytes.push_back(CHAR_CR);
        line_bytes.push_back(CHAR_VT);
        line_bytes.push_back(CHAR_FF);
        add_text("1");
        send_line();
        add_text("RPL? 4294967295 4294967295 9");
        send_line();
        // A bare terminator and a prefix mismatch.
        send_line();
        add_text("RPL!");
        send_line();
        // Too few fields, and a fourth field.
        add_text("RPL? 1 2");
        send_line();
        add_text("RPL? 1 2 3 4");
        send_line();
        // A high byte inside a field.
        add_text("RPL? 1");
        line_bytes.push_back(8'hFF);
        add_text(" 2 3");
        send_line();
        // Eleven digits made of leading zeros, and a value one past the top.
        add_text("RPL? 00000000001 2 3");
        send_line();
        add_text("RPL? 4294967296 5 6");
        send_line();
        // Inverted window and zero maximum.
        add_text("RPL? 5 4 1");
        send_line();
        add_text("RPL? 1 1 0");
        send_line();
        drain_verdicts();

        lines = 0;
        while (random_bytes < RANDOM_BYTES) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)      kind = LINE_GOOD;
            else if (pick < 65) kind = LINE_NOISE;
            else if (pick < 71) kind = LINE_BAD_PREFIX;
            else if (pick < 77) kind = LINE_BAD_CHAR;
            else if (pick < 83) kind = LINE_EXTRA_FIELD;
            else if (pick < 88) kind = LINE_TOO_LONG;
            else if (pick < 93) kind = LINE_OVERFLOW;
            else                kind = LINE_TRUNCATED;
            if (kind == LINE_NOISE) begin
                repeat ($urandom_range(1, 20))
                    line_bytes.push_back(8'($urandom_range(1, 255)));
            end else if (kind == LINE_BAD_PREFIX) begin
                build_bad_prefix();
            end else begin
                build_request(kind);
            end
            random_bytes += line_bytes.size() + 1;
            send_line();
            lines++;
            if (lines % 12 == 0) drain_verdicts();
        end

        // Let every verdict arrive, then allow for the pipeline.
        no_idle = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("replay_request_line_parser: match");
        end else begin
            $display("replay_request_line_parser: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/rrlp_pkg.sv
hw/rtl/rrlp_digit_acc.sv
hw/rtl/replay_request_line_parser.sv
sim/replay_request_line_parser_checker.sv
sim/replay_request_line_parser_tb.sv
